/* rtl/core/bc13_pkg.sv */
`default_nettype none

package bc13_pkg;

   localparam int unsigned BlockWidth  = 64;
   localparam int unsigned ReqWidth    = 2 * BlockWidth;
   localparam int unsigned RspWidth    = 40;
   localparam int unsigned NumTexels   = 16;
   localparam int unsigned CidxWidth   = 32;
   localparam int unsigned AidxWidth   = 48;

   localparam logic [7:0] AlphaOpaque      = 8'd255;
   localparam logic [7:0] AlphaTransparent = 8'd0;
   localparam logic [1:0] ColorTransparent = 2'd3;
   localparam logic [3:0] LastTexel        = 4'd15;

   // Per-block palette handed from the palette logic to the texel output stage.
   typedef struct packed {
      logic [3:0][7:0] red;
      logic [3:0][7:0] green;
      logic [3:0][7:0] blue;
      logic            three_color;
      logic [7:0][7:0] alpha_pal;
   } bc13_pal_type;

   function automatic logic [7:0] expand5(input logic [4:0] v);
      return {v, v[4:2]};
   endfunction

   function automatic logic [7:0] expand6(input logic [5:0] v);
      return {v, v[5:4]};
   endfunction

   // Truncating divides by small constants as reciprocal multiplies.
   // The reciprocal error stays below the gap to the next integer over the
   // operand range used here (sums of 8-bit channel values).
   function automatic logic [7:0] div3(input logic [9:0] x);
      logic [20:0] p;
      p = 21'(x) * 21'd683;
      return p[18:11];
   endfunction

   function automatic logic [7:0] div5(input logic [10:0] x);
      logic [21:0] p;
      p = 22'(x) * 22'd1639;
      return p[20:13];
   endfunction

   function automatic logic [7:0] div7(input logic [10:0] x);
      logic [22:0] p;
      p = 23'(x) * 23'd2341;
      return p[21:14];
   endfunction

endpackage

`default_nettype wire

/* rtl/core/bc13_palette.sv */
`default_nettype none

module bc13_palette (
   input  wire logic [bc13_pkg::BlockWidth-1:0] color_block,
   input  wire logic [bc13_pkg::BlockWidth-1:0] alpha_block,
   input  wire logic                            bc3_mode,
   output bc13_pkg::bc13_pal_type               pal
);

   import bc13_pkg::*;

   logic [15:0] c0;
   logic [15:0] c1;
   logic [7:0]  a0;
   logic [7:0]  a1;
   logic        four_color;
   logic [2:0][7:0] ch0;
   logic [2:0][7:0] ch1;
   logic [2:0][7:0] ch2;
   logic [2:0][7:0] ch3;

   assign c0 = color_block[15:0];
   assign c1 = color_block[31:16];
   assign a0 = alpha_block[7:0];
   assign a1 = alpha_block[15:8];

   assign four_color = bc3_mode || (c0 > c1);

   always_comb begin
      ch0[0] = expand5(c0[15:11]);
      ch0[1] = expand6(c0[10:5]);
      ch0[2] = expand5(c0[4:0]);
      ch1[0] = expand5(c1[15:11]);
      ch1[1] = expand6(c1[10:5]);
      ch1[2] = expand5(c1[4:0]);
      for (int c = 0; c < 3; c++) begin
         if (four_color) begin
            ch2[c] = div3({1'b0, ch0[c], 1'b0} + 10'(ch1[c]));
            ch3[c] = div3(10'(ch0[c]) + {1'b0, ch1[c], 1'b0});
         end else begin
            ch2[c] = 8'((9'(ch0[c]) + 9'(ch1[c])) >> 1);
            ch3[c] = 8'd0;
         end
      end
   end

   always_comb begin
      pal.red         = {ch3[0], ch2[0], ch1[0], ch0[0]};
      pal.green       = {ch3[1], ch2[1], ch1[1], ch0[1]};
      pal.blue        = {ch3[2], ch2[2], ch1[2], ch0[2]};
      pal.three_color = !four_color;

      // Alpha palette: six interpolated sevenths, or four fifths plus 0 and 255.
      pal.alpha_pal[0] = a0;
      pal.alpha_pal[1] = a1;
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++) begin
            pal.alpha_pal[k + 1] = div7(11'(a0) * 11'(7 - k) + 11'(a1) * 11'(k));
         end
      end else begin
         for (int k = 1; k <= 4; k++) begin
            pal.alpha_pal[k + 1] = div5(11'(a0) * 11'(5 - k) + 11'(a1) * 11'(k));
         end
         pal.alpha_pal[6] = AlphaTransparent;
         pal.alpha_pal[7] = AlphaOpaque;
      end
   end

endmodule

`default_nettype wire

/* rtl/core/bc1_bc3_block_decoder.sv */
`default_nettype none

// BC1/BC3 block decoder. Each request carries one compressed 4x4 block
// (color half in the low 64 bits, alpha half in the high 64 bits) and yields
// sixteen RGBA texels in raster order, the sixteenth marked with rsp_tlast.
// The result channel moves one texel per cycle unless rsp_tready stalls it;
// the block, palette and texel registers overlap, so the next block is taken
// while the current one drains, each block passing from the block register
// through the palette register into the texel register. The mode register
// (bit 0: 0 = BC1 with punch-through alpha, 1 = BC3) is set over csr_; the user
// must write it only while no block is in flight; the block does not enforce it.

module bc1_bc3_block_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [63:0] color_block, [127:64] alpha_block
   input  wire logic [bc13_pkg::ReqWidth-1:0]  req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha,
   // [35:32] texel_index, [39:36] zero
   output logic [bc13_pkg::RspWidth-1:0]       rsp_tdata,
   output logic                                rsp_tlast,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic                           csr_data
);

   import bc13_pkg::*;

   logic                    mode_ff;

   logic                    blk_vld_ff;
   logic [ReqWidth-1:0]     blk_ff;

   logic                    pal_vld_ff;
   bc13_pal_type            pal_ff;
   bc13_pal_type            pal_in;
   logic                    pal_mode_ff;
   logic [CidxWidth-1:0]    cidx_ff;
   logic [AidxWidth-1:0]    aidx_ff;
   logic [3:0]              cnt_ff;

   logic                    rsp_vld_ff;
   logic [RspWidth-1:0]     rsp_data_ff;
   logic                    rsp_last_ff;

   logic                    out_adv;
   logic                    emit;
   logic                    pal_done;
   logic                    pal_load;
   logic                    req_acc;
   logic [1:0]              ci;
   logic [2:0]              ai;
   logic [7:0]              alpha_sel;

   assign csr_ready = 1'b1;

   assign out_adv  = !rsp_vld_ff || rsp_tready;
   assign emit     = pal_vld_ff && out_adv;
   assign pal_done = emit && (cnt_ff == LastTexel);
   assign pal_load = blk_vld_ff && (!pal_vld_ff || pal_done);
   assign req_tready = !blk_vld_ff || pal_load;
   assign req_acc  = req_tvalid && req_tready;

   bc13_palette u_palette (
      .color_block (blk_ff[BlockWidth-1:0]),
      .alpha_block (blk_ff[ReqWidth-1:BlockWidth]),
      .bc3_mode    (mode_ff),
      .pal         (pal_in)
   );

   assign ci = cidx_ff[{cnt_ff, 1'b0} +: 2];
   assign ai = aidx_ff[6'(cnt_ff) * 6'd3 +: 3];

   always_comb begin
      if (pal_mode_ff) begin
         alpha_sel = pal_ff.alpha_pal[ai];
      end else if (pal_ff.three_color && (ci == ColorTransparent)) begin
         alpha_sel = AlphaTransparent;
      end else begin
         alpha_sel = AlphaOpaque;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= 1'b0;
         blk_vld_ff <= 1'b0;
         pal_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            mode_ff <= csr_data;
         end
         if (req_acc) begin
            blk_vld_ff <= 1'b1;
         end else if (pal_load) begin
            blk_vld_ff <= 1'b0;
         end
         if (pal_load) begin
            pal_vld_ff <= 1'b1;
         end else if (pal_done) begin
            pal_vld_ff <= 1'b0;
         end
         if (emit) begin
            cnt_ff <= cnt_ff + 4'd1;
         end
         if (out_adv) begin
            rsp_vld_ff <= pal_vld_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         blk_ff <= req_tdata;
      end
      if (pal_load) begin
         pal_ff      <= pal_in;
         pal_mode_ff <= mode_ff;
         cidx_ff     <= blk_ff[BlockWidth-1:BlockWidth-CidxWidth];
         aidx_ff     <= blk_ff[ReqWidth-1:ReqWidth-AidxWidth];
      end
      if (emit) begin
         rsp_data_ff <= {4'd0, cnt_ff, alpha_sel, pal_ff.blue[ci], pal_ff.green[ci],
                         pal_ff.red[ci]};
         rsp_last_ff <= (cnt_ff == LastTexel);
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // The texel counter only moves when a texel enters the result register.
   a_cnt_hold : assert property (@(posedge clock) disable iff (reset)
      (pal_vld_ff && !out_adv) |=> $stable(cnt_ff))
      else $error("texel counter moved while the result register was stalled");

   // A new request may overwrite the block register only as its block moves on.
   a_blk_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (req_acc && blk_vld_ff) |-> pal_load)
      else $error("block register overwritten before its palette was loaded");

   // The last marker goes with texel fifteen and no other.
   a_last_index : assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> (rsp_last_ff == (rsp_data_ff[35:32] == LastTexel)))
      else $error("last texel marker out of step with the texel index");

   // A block's first texel starts at index zero after a new palette load.
   a_cnt_start : assert property (@(posedge clock) disable iff (reset)
      (pal_load && !pal_vld_ff) |-> (cnt_ff == 4'd0))
      else $error("texel counter not at zero when a new block starts");
`endif

endmodule

`default_nettype wire

/* tb/bc1_bc3_block_decoder_tb.sv */
`timescale 1ns / 100ps

module bc1_bc3_block_decoder_tb;

   localparam bit ModeBc1 = 1'b0;
   localparam bit ModeBc3 = 1'b1;

   localparam logic [31:0] ColorIdxRamp = 32'hE4E4_E4E4;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [3:0] texel_index;
      logic       last_texel;
   } texel_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [bc13_pkg::ReqWidth-1:0] req_tdata = '0;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic [bc13_pkg::RspWidth-1:0] rsp_tdata;
   logic                          rsp_tlast;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic                          csr_data = 1'b0;

   logic [bc13_pkg::ReqWidth-1:0] block_q[$];
   texel_type                     texel_q[$];
   bit                            mode_shadow = ModeBc1;
   int unsigned                   req_idle_pct = 8;
   int unsigned                   rsp_stall_pct = 8;
   int unsigned                   fail_count = 0;

   bc1_bc3_block_decoder i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #6 clock = ~clock;

   function automatic logic [7:0] widen5(input logic [4:0] v);
      int unsigned x;
      x = v;
      return 8'((x << 3) | (x >> 2));
   endfunction

   function automatic logic [7:0] widen6(input logic [5:0] v);
      int unsigned x;
      x = v;
      return 8'((x << 2) | (x >> 4));
   endfunction

   // Works out the sixteen texels of one block and queues them in order.
   function automatic void predict_block_texels(input logic [63:0] cb, input logic [63:0] ab,
                                                input bit mode);
      int unsigned pr[4], pg[4], pb[4], pa[4], apal[8];
      int unsigned c0, c1, a0, a1, ci, ai;
      texel_type   t;
      c0 = cb[15:0];
      c1 = cb[31:16];
      pr[0] = widen5(cb[15:11]);
      pg[0] = widen6(cb[10:5]);
      pb[0] = widen5(cb[4:0]);
      pr[1] = widen5(cb[31:27]);
      pg[1] = widen6(cb[26:21]);
      pb[1] = widen5(cb[20:16]);
      for (int i = 0; i < 4; i++) pa[i] = 255;
      if (mode == ModeBc3 || c0 > c1) begin
         pr[2] = (2 * pr[0] + pr[1]) / 3;
         pg[2] = (2 * pg[0] + pg[1]) / 3;
         pb[2] = (2 * pb[0] + pb[1]) / 3;
         pr[3] = (pr[0] + 2 * pr[1]) / 3;
         pg[3] = (pg[0] + 2 * pg[1]) / 3;
         pb[3] = (pb[0] + 2 * pb[1]) / 3;
      end else begin
         // Three-color block: the fourth entry is transparent black.
         pr[2] = (pr[0] + pr[1]) / 2;
         pg[2] = (pg[0] + pg[1]) / 2;
         pb[2] = (pb[0] + pb[1]) / 2;
         pr[3] = 0;
         pg[3] = 0;
         pb[3] = 0;
         pa[3] = 0;
      end
      a0 = ab[7:0];
      a1 = ab[15:8];
      apal[0] = a0;
      apal[1] = a1;
      if (a0 > a1) begin
         for (int k = 1; k <= 6; k++) apal[k + 1] = ((7 - k) * a0 + k * a1) / 7;
      end else begin
         for (int k = 1; k <= 4; k++) apal[k + 1] = ((5 - k) * a0 + k * a1) / 5;
         apal[6] = 0;
         apal[7] = 255;
      end
      for (int i = 0; i < 16; i++) begin
         ci = cb[32 + 2 * i +: 2];
         ai = ab[16 + 3 * i +: 3];
         t.red         = 8'(pr[ci]);
         t.green       = 8'(pg[ci]);
         t.blue        = 8'(pb[ci]);
         t.alpha       = (mode == ModeBc3) ? 8'(apal[ai]) : 8'(pa[ci]);
         t.texel_index = 4'(i);
         t.last_texel  = (i == 15);
         texel_q.push_back(t);
      end
   endfunction

   // Request driver: takes blocks from block_q and predicts each accepted one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_block_texels(req_tdata[63:0], req_tdata[127:64], mode_shadow);
         end
         if (!req_tvalid || req_tready) begin
            if (block_q.size() != 0 && $urandom_range(99) >= req_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata  <= block_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Texel monitor: compares each accepted texel with the oldest prediction.
   always @(posedge clock) begin
      texel_type t;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (texel_q.size() == 0) begin
               $error("texel with no block pending: data %h last %b", rsp_tdata, rsp_tlast);
               fail_count++;
            end else begin
               t = texel_q.pop_front();
               if (rsp_tdata[7:0] !== t.red) begin
                  $error("red: expected %0d, actual %0d", t.red, rsp_tdata[7:0]);
                  fail_count++;
               end
               if (rsp_tdata[15:8] !== t.green) begin
                  $error("green: expected %0d, actual %0d", t.green, rsp_tdata[15:8]);
                  fail_count++;
               end
               if (rsp_tdata[23:16] !== t.blue) begin
                  $error("blue: expected %0d, actual %0d", t.blue, rsp_tdata[23:16]);
                  fail_count++;
               end
               if (rsp_tdata[31:24] !== t.alpha) begin
                  $error("alpha: expected %0d, actual %0d", t.alpha, rsp_tdata[31:24]);
                  fail_count++;
               end
               if (rsp_tdata[35:32] !== t.texel_index) begin
                  $error("texel_index: expected %0d, actual %0d", t.texel_index,
                         rsp_tdata[35:32]);
                  fail_count++;
               end
               if (rsp_tlast !== t.last_texel) begin
                  $error("last_texel: expected %0d, actual %0d", t.last_texel, rsp_tlast);
                  fail_count++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   function automatic logic [47:0] alpha_idx_ramp();
      logic [47:0] v;
      for (int i = 0; i < 16; i++) v[3 * i +: 3] = 3'(i);
      return v;
   endfunction

   task automatic add_block(input logic [15:0] c0, input logic [15:0] c1,
                            input logic [31:0] cidx, input logic [63:0] ab);
      block_q.push_back({ab, cidx, c1, c0});
   endtask

   task automatic add_random_blocks(input int n);
      logic [63:0] cb, ab;
      for (int i = 0; i < n; i++) begin
         cb = {$urandom, $urandom};
         ab = {$urandom, $urandom};
         // Equal and adjacent endpoints steer the palette mode boundaries.
         case ($urandom_range(5))
            0: cb[31:16] = cb[15:0];
            1: cb[31:16] = cb[15:0] + 16'd1;
            2: cb[15:0]  = cb[31:16] + 16'd1;
            default: ;
         endcase
         case ($urandom_range(5))
            0: ab[15:8] = ab[7:0];
            1: ab[15:8] = ab[7:0] + 8'd1;
            2: ab[7:0]  = ab[15:8] + 8'd1;
            default: ;
         endcase
         block_q.push_back({ab, cb});
      end
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (block_q.size() != 0 || req_tvalid || texel_q.size() != 0);
   endtask

   task automatic write_mode(input bit mode);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data  <= mode;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      mode_shadow = mode;
      csr_valid <= 1'b0;
   endtask

   initial begin
      #(5_000_000);
      $display("** bc1_bc3_block_decoder: FAILED **");
      $finish;
   end

   initial begin
      logic [47:0] ramp;
      ramp = alpha_idx_ramp();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // BC1 corners: palette mode boundaries, transparent black, ignored alpha.
      write_mode(ModeBc1);
      add_block(16'h0000, 16'h0000, 32'h0000_0000, 64'h0);
      add_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(16'hFFFF, 16'h0000, ColorIdxRamp, 64'h0);
      add_block(16'h0000, 16'hFFFF, ColorIdxRamp, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(16'hF800, 16'h07E0, 32'h1B1B_1B1B, {ramp, 16'h00FF});
      add_block(16'h8410, 16'h8410, ColorIdxRamp, 64'h0123_4567_89AB_CDEF);
      add_block(16'h8411, 16'h8410, ColorIdxRamp, 64'h0);
      add_block(16'h001F, 16'hFFE0, 32'h5A5A_A5A5, 64'h0);
      add_block(16'h07E0, 16'h001F, 32'hFFFF_0000, 64'h0);
      wait_drained();

      // BC3 corners: both alpha palette modes and their endpoints.
      write_mode(ModeBc3);
      add_block(16'h0000, 16'hFFFF, ColorIdxRamp, {ramp, 8'h00, 8'hFF});
      add_block(16'hFFFF, 16'h0000, ColorIdxRamp, {ramp, 8'hFF, 8'h00});
      add_block(16'h8410, 16'h8410, ColorIdxRamp, {ramp, 8'h80, 8'h80});
      add_block(16'h1234, 16'h5678, 32'hE4E4_1B1B, {ramp, 8'h80, 8'h81});
      add_block(16'h5678, 16'h1234, 32'h1B1B_E4E4, {ramp, 8'h40, 8'h3F});
      add_block(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
      add_block(16'h0000, 16'h0000, 32'h0000_0000, 64'h0);
      add_block(16'hF800, 16'h07E0, ColorIdxRamp, {~ramp, 8'h11, 8'hEE});
      add_block(16'h0001, 16'hFFFE, 32'hAAAA_5555, {ramp, 8'hFE, 8'h01});
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_mode((p % 2 == 0) ? ModeBc1 : ModeBc3);
         // One pair of phases runs with both sides streaming without gaps.
         req_idle_pct  = (p >= 2 && p <= 3) ? 0 : 8;
         rsp_stall_pct = (p >= 2 && p <= 3) ? 0 : 8;
         add_random_blocks(45);
         wait_drained();
      end

      req_idle_pct  = 8;
      rsp_stall_pct = 8;
      repeat (40) @(posedge clock);
      if (fail_count == 0) begin
         $display("** bc1_bc3_block_decoder: PASSED **");
      end else begin
         $display("** bc1_bc3_block_decoder: FAILED **");
      end
      $finish;
   end

endmodule
